// File: sv/memory_map_bus_decoder_core_defines.svh
// Assertion helpers for the bus decoder, sampled on clk, off during reset.
`ifndef MEMORY_MAP_BUS_DECODER_CORE_DEFINES_SVH
`define MEMORY_MAP_BUS_DECODER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MMBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define MMBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mmbd_pkg.sv
package mmbd_pkg;

    localparam int RAM_BYTES = 2097152;
    localparam int ROM_BYTES = 524288;
    localparam int RAM_WORDS = (RAM_BYTES + 3) / 4;
    localparam int ROM_WORDS = (ROM_BYTES + 3) / 4;
    localparam int RAM_AW    = $clog2(RAM_WORDS);
    localparam int ROM_AW    = $clog2(ROM_WORDS);

    localparam int NUM_MASKS = 8;
    localparam int CFG_IDX_W = $clog2(NUM_MASKS);

    localparam logic [31:0] MASK_RESET [NUM_MASKS] = '{
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h7FFF_FFFF, 32'h1FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
    };

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_STORE = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [7:0] TOP_RAM   = 8'h00;
    localparam logic [7:0] TOP_SYS   = 8'h1F;
    localparam logic [7:0] TOP_CACHE = 8'hFF;

    localparam logic [3:0] MID_IO  = 4'h8;
    localparam logic [3:0] MID_ROM = 4'hC;

    localparam logic [3:0] SUB_SCRATCH = 4'h0;
    localparam logic [3:0] SUB_IO      = 4'h1;
    localparam logic [3:0] SUB_EXP2    = 4'h2;

    localparam logic [31:0] ROM_BASE      = 32'h1FC0_0000;
    localparam logic [31:0] SCRATCH_BASE  = 32'h1F80_0000;
    localparam logic [31:0] CACHE_BASE    = 32'hFFFE_0000;
    localparam logic [31:0] IO_ZERO_ADDR  = 32'h1F80_1074;
    localparam logic [31:0] SCRATCH_BYTES = 32'd1024;
    localparam logic [31:0] CACHE_BYTES   = 32'd512;
    localparam logic [31:0] EXP1_DATA     = 32'h0000_00FF;
    localparam logic [7:0]  RAM_FILL_BYTE = 8'hCA;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_IGNORED = 2'd1,
        STATUS_FAULT   = 2'd2,
        STATUS_RANGE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_RAM_LOAD,
        OP_RAM_STORE,
        OP_ROM_LOAD
    } op_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MEM
    } state_t;

endpackage

// File: sv/mmbd_ram.sv
module mmbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/memory_map_bus_decoder_core.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: address, access_size, write_data; tuser: mode
// m_*       out  m_tvalid/m_tready  tdata: read_data; tuser: status
// cfg_*     in   cfg_wr_en          cfg_index selects one of eight region masks
//
// RAM loads, RAM stores and ROM loads go through S_MEM: one synchronous memory read,
// then the lane merge and write back. Every other item is answered straight from S_IDLE.
// After reset the main RAM is swept to 0xCA, one word a cycle, over all RAM_WORDS
// (524288) words; no item is accepted during the sweep.
// A held result stalls input only when the result register cannot drain.
`include "memory_map_bus_decoder_core_defines.svh"

module memory_map_bus_decoder_core
    import mmbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,   // address[31:0], access_size[33:32], write_data[65:34]
    input  logic [1:0]           s_tuser,   // mode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // read_data[31:0]
    output logic [1:0]           m_tuser,   // status[1:0]
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    state_t state_reg, state_next;
    logic [RAM_AW-1:0] clear_cnt_reg, clear_cnt_next;
    logic [31:0] mask_reg [NUM_MASKS];

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_rdata_reg, m_rdata_next;
    status_t     m_status_reg, m_status_next;

    op_t         pend_op_reg;
    logic [1:0]  pend_off_reg;
    logic [1:0]  pend_size_reg;
    logic [31:0] pend_wdata_reg;
    logic [RAM_AW-1:0] pend_widx_reg;

    logic [1:0]  mode_in, size_in;
    logic [31:0] addr_in, wdata_in;
    logic        s_accept, is_load;
    logic [2:0]  nbytes;
    logic [31:0] a_al, a, rom_rel, fill_off;
    logic [32:0] ram_end, rom_end, fill_end;
    logic [7:0]  top;
    logic [3:0]  mid, sub;

    status_t     dec_status;
    logic [31:0] dec_rdata;
    logic        dec_mem, dec_fill;
    op_t         dec_op;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;
    logic              rom_we;
    logic [ROM_AW-1:0] rom_waddr, rom_raddr;
    logic [31:0]       rom_rdata;

    logic [31:0] mem_word, load_sh, load_val, store_sh, merged;
    logic [3:0]  lane_en;

    assign mode_in  = s_tuser;
    assign addr_in  = s_tdata[31:0];
    assign size_in  = s_tdata[33:32];
    assign wdata_in = s_tdata[65:34];
    assign s_accept = s_tvalid && s_tready;
    assign is_load  = (mode_in == MODE_LOAD);

    always_comb
    begin
        case (size_in)
            SIZE_BYTE:
            begin
                nbytes = 3'd1;
                a_al   = addr_in;
            end
            SIZE_HALF:
            begin
                nbytes = 3'd2;
                a_al   = {addr_in[31:1], 1'b0};
            end
            default:
            begin
                nbytes = 3'd4;
                a_al   = {addr_in[31:2], 2'b00};
            end
        endcase
    end

    assign a        = a_al & mask_reg[addr_in[31:29]];
    assign top      = a[31:24];
    assign mid      = a[23:20];
    assign sub      = a[15:12];
    assign rom_rel  = a - ROM_BASE;
    assign fill_off = {addr_in[31:2], 2'b00};
    assign ram_end  = {1'b0, a} + 33'(nbytes);
    assign rom_end  = {1'b0, rom_rel} + 33'(nbytes);
    assign fill_end = {1'b0, fill_off} + 33'd4;

    always_comb
    begin
        dec_status = STATUS_FAULT;
        dec_rdata  = '0;
        dec_mem    = 1'b0;
        dec_fill   = 1'b0;
        dec_op     = OP_RAM_LOAD;
        if (mode_in == MODE_FILL)
        begin
            if (fill_end <= 33'(ROM_BYTES))
            begin
                dec_fill   = 1'b1;
                dec_status = STATUS_DONE;
            end
            else
            begin
                dec_status = STATUS_RANGE;
            end
        end
        else if (mode_in == MODE_LOAD || mode_in == MODE_STORE)
        begin
            if (top == TOP_RAM)
            begin
                if (ram_end > 33'(RAM_BYTES))
                begin
                    dec_status = STATUS_RANGE;
                end
                else
                begin
                    dec_mem    = 1'b1;
                    dec_status = STATUS_DONE;
                    dec_op     = is_load ? OP_RAM_LOAD : OP_RAM_STORE;
                end
            end
            else if (top == TOP_SYS)
            begin
                unique case (mid) inside
                    [4'h0:4'h7]:
                    begin
                        if (is_load)
                        begin
                            dec_rdata  = EXP1_DATA;
                            dec_status = STATUS_DONE;
                        end
                    end
                    MID_IO:
                    begin
                        unique case (sub)
                            SUB_SCRATCH:
                                dec_status = ((a - SCRATCH_BASE) < SCRATCH_BYTES)
                                             ? STATUS_FAULT : STATUS_RANGE;
                            SUB_IO:
                            begin
                                if (!is_load)
                                    dec_status = STATUS_IGNORED;
                                else if (a == IO_ZERO_ADDR)
                                    dec_status = STATUS_DONE;
                            end
                            SUB_EXP2:
                                dec_status = is_load ? STATUS_FAULT : STATUS_IGNORED;
                            default:
                                dec_status = STATUS_FAULT;
                        endcase
                    end
                    MID_ROM:
                    begin
                        if (!is_load)
                        begin
                            dec_status = STATUS_IGNORED;
                        end
                        else if (rom_end > 33'(ROM_BYTES))
                        begin
                            dec_status = STATUS_RANGE;
                        end
                        else
                        begin
                            dec_mem    = 1'b1;
                            dec_status = STATUS_DONE;
                            dec_op     = OP_ROM_LOAD;
                        end
                    end
                    default:
                        dec_status = STATUS_FAULT;
                endcase
            end
            else if (top == TOP_CACHE)
            begin
                if ((a - CACHE_BASE) >= CACHE_BYTES)
                    dec_status = STATUS_RANGE;
                else
                    dec_status = is_load ? STATUS_FAULT : STATUS_IGNORED;
            end
        end
    end

    always_comb
    begin
        case (pend_size_reg)
            SIZE_BYTE: lane_en = 4'b0001 << pend_off_reg;
            SIZE_HALF: lane_en = 4'b0011 << pend_off_reg;
            default:   lane_en = 4'b1111;
        endcase
        mem_word = (pend_op_reg == OP_ROM_LOAD) ? rom_rdata : ram_rdata;
        load_sh  = mem_word >> {pend_off_reg, 3'b000};
        store_sh = pend_wdata_reg << {pend_off_reg, 3'b000};
        case (pend_size_reg)
            SIZE_BYTE: load_val = {24'b0, load_sh[7:0]};
            SIZE_HALF: load_val = {16'b0, load_sh[15:0]};
            default:   load_val = load_sh;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            merged[i*8 +: 8] = lane_en[i] ? store_sh[i*8 +: 8] : mem_word[i*8 +: 8];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + RAM_AW'(1);
                if (clear_cnt_reg == RAM_AW'(RAM_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_accept && dec_mem)
                    state_next = S_MEM;
            end
            S_MEM:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = pend_widx_reg;
        ram_wdata     = merged;
        m_valid_next  = m_valid_reg && !m_tready;
        m_rdata_next  = m_rdata_reg;
        m_status_next = m_status_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clear_cnt_reg;
                ram_wdata = {4{RAM_FILL_BYTE}};
            end
            S_IDLE:
            begin
                s_tready = !m_valid_reg || m_tready;
                if (s_accept && !dec_mem)
                begin
                    m_valid_next  = 1'b1;
                    m_rdata_next  = dec_rdata;
                    m_status_next = dec_status;
                end
            end
            S_MEM:
            begin
                ram_we        = (pend_op_reg == OP_RAM_STORE);
                m_valid_next  = 1'b1;
                m_rdata_next  = (pend_op_reg == OP_RAM_STORE) ? 32'd0 : load_val;
                m_status_next = STATUS_DONE;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign ram_raddr = a[2 +: RAM_AW];
    assign rom_raddr = rom_rel[2 +: ROM_AW];
    assign rom_we    = s_accept && dec_fill;
    assign rom_waddr = fill_off[2 +: ROM_AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_MASKS; i++)
            begin
                mask_reg[i] <= MASK_RESET[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en)
            begin
                mask_reg[cfg_index] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_rdata_reg  <= m_rdata_next;
        m_status_reg <= m_status_next;
        if (s_accept)
        begin
            pend_op_reg    <= dec_op;
            pend_off_reg   <= a[1:0];
            pend_size_reg  <= size_in;
            pend_wdata_reg <= wdata_in;
            pend_widx_reg  <= a[2 +: RAM_AW];
        end
    end

    mmbd_ram #(
        .WIDTH (32),
        .DEPTH (RAM_WORDS)
    ) u_main_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mmbd_ram #(
        .WIDTH (32),
        .DEPTH (ROM_WORDS)
    ) u_boot_rom (
        .clk   (clk),
        .we    (rom_we),
        .waddr (rom_waddr),
        .wdata (wdata_in),
        .raddr (rom_raddr),
        .rdata (rom_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_rdata_reg;
    assign m_tuser  = m_status_reg;

    `MMBD_ASSERT_NOW(a_no_accept_in_clear, state_reg == S_CLEAR, !s_tready,
        "item accepted during RAM sweep")
    `MMBD_ASSERT_NEXT(a_mem_follows_accept, s_accept && dec_mem, state_reg == S_MEM,
        "memory access did not enter the memory phase")
    `MMBD_ASSERT_NOW(a_out_free_in_mem, state_reg == S_MEM, !m_valid_reg,
        "result register busy during memory phase")
    `MMBD_ASSERT_NEXT(a_mem_gives_result, state_reg == S_MEM, m_valid_reg,
        "memory phase produced no result")
    `MMBD_ASSERT_NOW(a_ram_write_phase, ram_we,
        state_reg == S_CLEAR || state_reg == S_MEM,
        "RAM written outside sweep or memory phase")

endmodule

// File: sim/testbench.sv
module testbench
    import mmbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_WIDE = 2'd3;
    localparam int STALL_LIMIT = 1600000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [1:0]  size;
        logic [31:0] wdata;
    } bus_access_t;

    typedef struct packed {
        logic [31:0] read_data;
        status_t     status;
    } bus_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata = '0;   // address[31:0], access_size[33:32], write_data[65:34]
    logic [1:0]           s_tuser = '0;   // mode[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;        // read_data[31:0]
    logic [1:0]           m_tuser;        // status[1:0]
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;

    bus_access_t pending_accesses [$];
    bus_reply_t  replies_due [$];
    bus_access_t cur_access;

    logic [31:0] region_mask [NUM_MASKS];
    logic [7:0]  ram_image [int unsigned];
    logic [7:0]  rom_image [int unsigned];
    bit          rom_word_planned [int unsigned];
    int unsigned planned_rom_words [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int reply_index = 0;
    int quiet_cycles = 0;

    memory_map_bus_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] byte_count(logic [1:0] size);
        if (size == SIZE_BYTE)
            return 32'd1;
        else if (size == SIZE_HALF)
            return 32'd2;
        return 32'd4;
    endfunction

    function automatic logic [31:0] region_masked_addr(bus_access_t acc);
        return (acc.address & ~(byte_count(acc.size) - 32'd1)) & region_mask[acc.address[31:29]];
    endfunction

    function automatic bus_reply_t decode_access(bus_access_t acc);
        bus_reply_t  r;
        logic [31:0] nbytes;
        logic [31:0] a;
        logic [31:0] rel;
        logic [31:0] key;
        logic        is_load;
        r.read_data = '0;
        r.status = STATUS_FAULT;
        nbytes = byte_count(acc.size);
        is_load = (acc.mode == MODE_LOAD);
        if (acc.mode == MODE_FILL)
        begin
            rel = acc.address & ~32'd3;
            if (longint'(rel) + 4 <= ROM_BYTES)
            begin
                for (int i = 0; i < 4; i++)
                    rom_image[rel + i] = acc.wdata[8*i +: 8];
                r.status = STATUS_DONE;
            end
            else
                r.status = STATUS_RANGE;
        end
        else if (acc.mode == MODE_LOAD || acc.mode == MODE_STORE)
        begin
            a = region_masked_addr(acc);
            if (a[31:24] == TOP_RAM)
            begin
                if (longint'(a) + nbytes > RAM_BYTES)
                    r.status = STATUS_RANGE;
                else
                begin
                    for (int i = 0; i < nbytes; i++)
                    begin
                        key = a + i;
                        if (is_load)
                            r.read_data[8*i +: 8] = ram_image.exists(key) ? ram_image[key]
                                                                          : RAM_FILL_BYTE;
                        else
                            ram_image[key] = acc.wdata[8*i +: 8];
                    end
                    r.status = STATUS_DONE;
                end
            end
            else if (a[31:24] == TOP_SYS)
            begin
                if (a[23:20] <= 4'd7)
                begin
                    if (is_load)
                    begin
                        r.read_data = EXP1_DATA;
                        r.status = STATUS_DONE;
                    end
                end
                else if (a[23:20] == MID_IO)
                begin
                    case (a[15:12])
                        SUB_SCRATCH:
                            r.status = (a - SCRATCH_BASE) < SCRATCH_BYTES ? STATUS_FAULT
                                                                          : STATUS_RANGE;
                        SUB_IO:
                            if (!is_load)
                                r.status = STATUS_IGNORED;
                            else if (a == IO_ZERO_ADDR)
                                r.status = STATUS_DONE;
                        SUB_EXP2:
                            r.status = is_load ? STATUS_FAULT : STATUS_IGNORED;
                        default:
                            r.status = STATUS_FAULT;
                    endcase
                end
                else if (a[23:20] == MID_ROM)
                begin
                    if (!is_load)
                        r.status = STATUS_IGNORED;
                    else
                    begin
                        rel = a - ROM_BASE;
                        if (longint'(rel) + nbytes > ROM_BYTES)
                            r.status = STATUS_RANGE;
                        else
                        begin
                            for (int i = 0; i < nbytes; i++)
                            begin
                                key = rel + i;
                                r.read_data[8*i +: 8] = rom_image.exists(key) ? rom_image[key]
                                                                              : 8'h00;
                            end
                            r.status = STATUS_DONE;
                        end
                    end
                end
            end
            else if (a[31:24] == TOP_CACHE)
            begin
                if ((a - CACHE_BASE) >= CACHE_BYTES)
                    r.status = STATUS_RANGE;
                else
                    r.status = is_load ? STATUS_FAULT : STATUS_IGNORED;
            end
        end
        return r;
    endfunction

    // queue an access, turning a load of a never-filled ROM word into a fill of that word
    task automatic queue_access(logic [1:0] mode, logic [31:0] address, logic [1:0] size,
                                logic [31:0] wdata);
        bus_access_t acc;
        logic [31:0] a;
        logic [31:0] rel;
        logic [31:0] word;
        acc.mode = mode;
        acc.address = address;
        acc.size = size;
        acc.wdata = wdata;
        if (acc.mode == MODE_LOAD)
        begin
            a = region_masked_addr(acc);
            rel = a - ROM_BASE;
            if (a[31:24] == TOP_SYS && a[23:20] == MID_ROM
                && longint'(rel) + byte_count(acc.size) <= ROM_BYTES
                && !rom_word_planned.exists(rel >> 2))
            begin
                acc.mode = MODE_FILL;
                acc.address = rel;
            end
        end
        if (acc.mode == MODE_FILL && longint'(acc.address & ~32'd3) + 4 <= ROM_BYTES)
        begin
            word = acc.address >> 2;
            if (!rom_word_planned.exists(word))
            begin
                rom_word_planned[word] = 1'b1;
                planned_rom_words.push_back(word);
            end
        end
        pending_accesses.push_back(acc);
    endtask

    function automatic logic [31:0] with_segment(logic [31:0] low);
        logic [2:0] seg;
        case ($urandom_range(0, 2))
            0: seg = 3'd0;
            1: seg = 3'd4;
            default: seg = 3'd5;
        endcase
        return {seg, low[28:0]};
    endfunction

    task automatic queue_random_access();
        int          pick;
        int          lane;
        logic [1:0]  mode;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
        pick = $urandom_range(0, 99);
        mode = $urandom_range(0, 1) ? MODE_STORE : MODE_LOAD;
        size = 2'($urandom_range(0, 3));
        wdata = $urandom();
        lane = $urandom_range(0, 9);
        if (pick < 28)
        begin
            if (lane < 8)
                addr = $urandom_range(0, 1023);
            else if (lane < 9)
                addr = RAM_BYTES - $urandom_range(1, 64);
            else
                addr = RAM_BYTES + $urandom_range(0, 64);
            addr = with_segment(addr);
        end
        else if (pick < 40)
        begin
            mode = MODE_FILL;
            if (lane < 8)
                addr = $urandom_range(0, 1023);
            else if (lane < 9)
                addr = ROM_BYTES - $urandom_range(1, 16);
            else
                addr = $urandom_range(0, 1) ? ROM_BYTES + $urandom_range(0, 64) : $urandom();
        end
        else if (pick < 52)
        begin
            if (planned_rom_words.size() == 0 || lane == 9)
                addr = ROM_BASE + ROM_BYTES + $urandom_range(0, 255);
            else
                addr = ROM_BASE + 4 * planned_rom_words[$urandom_range(0,
                           planned_rom_words.size() - 1)] + $urandom_range(0, 3);
            if (lane < 7)
                mode = MODE_LOAD;
            addr = with_segment(addr);
        end
        else if (pick < 60)
            addr = with_segment(lane < 3 ? IO_ZERO_ADDR : 32'h1F80_1000 + $urandom_range(0, 4095));
        else if (pick < 66)
            addr = with_segment(32'h1F00_0000 + $urandom_range(0, 32'h7F_FFFF));
        else if (pick < 71)
            addr = with_segment(SCRATCH_BASE + $urandom_range(0, 2047));
        else if (pick < 76)
            addr = with_segment(32'h1F80_2000 + $urandom_range(0, 4095));
        else if (pick < 80)
            addr = with_segment({8'h1F, 24'($urandom())});
        else if (pick < 88)
            addr = lane < 8 ? CACHE_BASE + $urandom_range(0, 1023) : {8'hFF, 24'($urandom())};
        else
        begin
            mode = 2'($urandom_range(0, 3));
            addr = $urandom();
        end
        queue_access(mode, addr, size, wdata);
    endtask

    task automatic load_masks(input logic [31:0] masks [NUM_MASKS]);
        for (int i = 0; i < NUM_MASKS; i++)
        begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= masks[i];
            region_mask[i] = masks[i];
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_bus();
        do
            @(negedge clk);
        while (pending_accesses.size() != 0 || s_tvalid || replies_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                replies_due.push_back(decode_access(cur_access));
            if (!s_tvalid || s_tready)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_access = pending_accesses.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, cur_access.wdata, cur_access.size, cur_access.address};
                    s_tuser <= cur_access.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        bus_reply_t want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected item %0d: read_data %h status %0d",
                                 reply_index, m_tdata, m_tuser);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (m_tdata !== want.read_data || m_tuser !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("item %0d: read_data exp %h got %h, status exp %0d got %0d",
                                     reply_index, want.read_data, m_tdata, want.status, m_tuser);
                    end
                end
                reply_index++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] masks [NUM_MASKS];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        masks = MASK_RESET;
        load_masks(masks);

        send_idle_pct = 34;
        recv_idle_pct = 69;
        queue_access(MODE_LOAD, 32'h0000_0000, SIZE_WORD, 32'h0);
        queue_access(MODE_STORE, 32'h0000_0000, SIZE_WORD, 32'hFFFF_FFFF);
        queue_access(MODE_STORE, 32'h8000_0007, SIZE_BYTE, 32'h1234_5678);
        queue_access(MODE_LOAD, 32'hA000_0005, SIZE_HALF, 32'h0);
        queue_access(MODE_LOAD, 32'h0000_0006, SIZE_WIDE, 32'h0);
        queue_access(MODE_STORE, 32'h001F_FFFC, SIZE_WORD, 32'h0000_0000);
        queue_access(MODE_LOAD, 32'h001F_FFFE, SIZE_HALF, 32'h0);
        queue_access(MODE_LOAD, 32'h0020_0000, SIZE_BYTE, 32'h0);
        queue_access(MODE_NONE, 32'hFFFF_FFFF, SIZE_WIDE, 32'hFFFF_FFFF);
        queue_access(MODE_FILL, 32'h0000_0000, SIZE_BYTE, 32'hDEAD_BEEF);
        queue_access(MODE_FILL, 32'h0007_FFFF, SIZE_WORD, 32'hFFFF_FFFF);
        queue_access(MODE_FILL, 32'h0008_0000, SIZE_WORD, 32'h1111_1111);
        queue_access(MODE_FILL, 32'hFFFF_FFFF, SIZE_WORD, 32'h2222_2222);
        queue_access(MODE_LOAD, 32'hBFC0_0000, SIZE_WORD, 32'h0);
        queue_access(MODE_LOAD, 32'h9FC7_FFFF, SIZE_BYTE, 32'h0);
        queue_access(MODE_LOAD, 32'h1FC8_0000, SIZE_WORD, 32'h0);
        queue_access(MODE_STORE, 32'h1FC0_0000, SIZE_WORD, 32'h3333_3333);
        queue_access(MODE_LOAD, 32'h1F00_0000, SIZE_WORD, 32'h0);
        queue_access(MODE_STORE, 32'h1F7F_FFFF, SIZE_BYTE, 32'h44);
        queue_access(MODE_LOAD, 32'h1F80_0000, SIZE_WORD, 32'h0);
        queue_access(MODE_LOAD, 32'h1F80_0400, SIZE_BYTE, 32'h0);
        queue_access(MODE_LOAD, 32'h1F80_1074, SIZE_WORD, 32'h0);
        queue_access(MODE_LOAD, 32'h1F80_1070, SIZE_WORD, 32'h0);
        queue_access(MODE_STORE, 32'h1F80_1074, SIZE_WORD, 32'h5555_5555);
        queue_access(MODE_LOAD, 32'h1F80_2000, SIZE_HALF, 32'h0);
        queue_access(MODE_STORE, 32'h1F80_2000, SIZE_HALF, 32'h6666);
        queue_access(MODE_LOAD, 32'h1FA0_0000, SIZE_WORD, 32'h0);
        queue_access(MODE_LOAD, 32'h1F90_0000, SIZE_WORD, 32'h0);
        queue_access(MODE_LOAD, 32'h1F80_3000, SIZE_WORD, 32'h0);
        queue_access(MODE_STORE, 32'hFFFE_0130, SIZE_WORD, 32'h7777_7777);
        queue_access(MODE_LOAD, 32'hFFFE_01FC, SIZE_WORD, 32'h0);
        queue_access(MODE_LOAD, 32'hFFFE_0200, SIZE_WORD, 32'h0);
        queue_access(MODE_LOAD, 32'hFFFF_FFFF, SIZE_WORD, 32'h0);
        queue_access(MODE_LOAD, 32'h4000_0000, SIZE_WORD, 32'h0);
        for (int n = 0; n < 620; n++)
            queue_random_access();
        drain_bus();

        masks = '{32'h0000_0000, $urandom(), 32'hFFFF_FFFF, $urandom(),
                  32'hFFFF_FFFF, 32'h1FFF_FFFF, $urandom(), 32'hFFFF_FFFF};
        load_masks(masks);
        send_idle_pct = 69;
        recv_idle_pct = 34;
        for (int n = 0; n < 620; n++)
            queue_random_access();
        drain_bus();

        for (int i = 0; i < NUM_MASKS; i++)
        begin
            case ($urandom_range(0, 5))
                0: masks[i] = 32'h0000_0000;
                1: masks[i] = 32'hFFFF_FFFF;
                2: masks[i] = 32'h7FFF_FFFF;
                3: masks[i] = 32'h1FFF_FFFF;
                4: masks[i] = 32'h001F_FFFF;
                default: masks[i] = $urandom();
            endcase
        end
        load_masks(masks);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 610; n++)
            queue_random_access();
        drain_bus();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
